/* hdl/sequential_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another on the next clock edge.
`define SLE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* hdl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// Sequential list engine package
// Beat types, mode codes and default sizes for the list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 8;
  localparam int CNT_W         = 8;
  localparam int MODE_W        = 3;
  localparam int DEPTH_DEFAULT = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         found_position;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

/* hdl/sequential_list_engine.sv */
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of signed 32-bit values held in a memory with one read and one
// write port, with insert, change, get, locate and clear requests.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_stall  | mode, position, value
//  rsp     | out       | rsp_valid/rsp_stall  | ok, read_value, found_position,
//          |           |                      | count
//
// Each request beat produces exactly one response beat. Clear, change, an
// append at the tail and failed requests go from acceptance straight to the
// done state, get passes through the get state, locate walks the entries in
// the scan state and any other insert walks the shift state and then the put
// state, the insert walk being paced by one memory read and one write per cycle.
// Reset clears the element count and the control state; the memory contents
// are left alone, as only entries below the count are ever used.
// A stalled response does not block the next request: the engine runs it and
// then holds its result until the response register has been emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  `include "sequential_list_engine_macros.svh"

  localparam int AW = $clog2(DEPTH);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GET   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  // The request being worked on, the element count and the walk index.
  req_t             cur;
  logic [CNT_W-1:0] count, count_next;
  logic [AW-1:0]    idx, idx_next;
  rsp_t             res, res_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  // Element memory with a registered read port.
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic req_fire;
  logic rsp_free;
  logic pos_in_list;
  logic pos_insertable;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // A position names an existing entry when it lies in 1..count; an insert
  // may also append at count + 1, provided the store still has room.
  assign pos_in_list    = (req.position != '0) && (req.position <= count);
  assign pos_insertable = (req.position != '0)
                       && ({1'b0, req.position} <= ({1'b0, count} + 9'd1))
                       && (count < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = req.value;
    mem_raddr      = '0;

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          res_next   = '0;
          state_next = S_DONE;
          case (req.mode)
            MODE_INSERT: begin
              if (pos_insertable) begin
                if ({1'b0, req.position} == ({1'b0, count} + 9'd1)) begin
                  // Appending at the tail needs no shift.
                  mem_we      = 1'b1;
                  mem_waddr   = AW'(req.position - 8'd1);
                  count_next  = count + 8'd1;
                  res_next.ok = 1'b1;
                end else begin
                  // Walk down from the last entry, moving each one up a slot.
                  mem_raddr  = AW'(count - 8'd1);
                  idx_next   = AW'(count - 8'd1);
                  state_next = S_SHIFT;
                end
              end
            end
            MODE_CHANGE: begin
              if (pos_in_list) begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(req.position - 8'd1);
                res_next.ok = 1'b1;
              end
            end
            MODE_GET: begin
              if (pos_in_list) begin
                mem_raddr  = AW'(req.position - 8'd1);
                state_next = S_GET;
              end
            end
            MODE_LOCATE: begin
              if (count != '0) begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            MODE_CLEAR: begin
              count_next  = '0;
              res_next.ok = 1'b1;
            end
            default: begin
              res_next.ok = 1'b0;
            end
          endcase
        end
      end

      S_GET: begin
        res_next.ok         = 1'b1;
        res_next.read_value = mem_rdata;
        state_next          = S_DONE;
      end

      S_SCAN: begin
        // mem_rdata holds entry idx; the next entry is fetched alongside.
        mem_raddr = AW'(idx + 1'b1);
        if (mem_rdata == cur.value) begin
          res_next.ok             = 1'b1;
          res_next.found_position = CNT_W'(idx) + 8'd1;
          state_next              = S_DONE;
        end else if ((CNT_W'(idx) + 8'd1) == count) begin
          state_next = S_DONE;
        end else begin
          idx_next = AW'(idx + 1'b1);
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx + 1'b1);
        mem_wdata = mem_rdata;
        if (CNT_W'(idx) == (cur.position - 8'd1)) begin
          state_next = S_PUT;
        end else begin
          mem_raddr = AW'(idx - 1'b1);
          idx_next  = AW'(idx - 1'b1);
        end
      end

      S_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(cur.position - 8'd1);
        mem_wdata   = cur.value;
        count_next  = count + 8'd1;
        res_next.ok = 1'b1;
        state_next  = S_DONE;
      end

      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          rsp_next.count = count;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur <= req;
    end
    idx <= idx_next;
    res <= res_next;
    rsp <= rsp_next;
  end

  `SLE_ASSERT_ALWAYS(a_count_range, count <= CNT_W'(DEPTH), "element count above depth")
  `SLE_ASSERT_ALWAYS(a_shift_in_list, (state != S_SHIFT) || (CNT_W'(idx) < count),
    "shift source beyond the list")
  `SLE_ASSERT_ALWAYS(a_write_state,
    !mem_we || (state == S_IDLE) || (state == S_SHIFT) || (state == S_PUT),
    "memory write outside a writing state")
  `SLE_ASSERT_NEXT(a_done_loads, (state == S_DONE) && rsp_free,
    rsp_valid && (state == S_IDLE), "finished result not moved to the response")

endmodule
